// File: rtl/core/m68kocd_pkg.sv
// Shared types and constants for the 68000 opcode class decoder.
package m68kocd_pkg;

    localparam int OPCODE_W = 16;
    localparam int CLASS_W  = 7;
    localparam int OUT_TDATA_W = 8;

    // Special-case field values used by the decode.
    localparam logic [7:0] LOW8_CCR    = 8'h3C;   // immediate-to-CCR form
    localparam logic [5:0] EA_ILLEGAL  = 6'o74;   // ILLEGAL effective-address code
    localparam logic [4:0] SEL_DBCC    = 5'd25;   // line 5 bits 7:3 for DBcc
    localparam logic [4:0] SEL_SBCD    = 5'd16;   // line 8 bits 8:4 for SBCD

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE            = 7'd0,
        CLS_CMPI            = 7'd1,
        CLS_EORI_CCR        = 7'd2,
        CLS_EORI            = 7'd3,
        CLS_ADDI            = 7'd4,
        CLS_SUBI            = 7'd5,
        CLS_ANDI_CCR        = 7'd6,
        CLS_ANDI            = 7'd7,
        CLS_ORI_CCR         = 7'd8,
        CLS_ORI             = 7'd9,
        CLS_STATIC_BIT      = 7'd10,
        CLS_MOVEP           = 7'd11,
        CLS_DYNAMIC_BIT     = 7'd12,
        CLS_MOVEA           = 7'd13,
        CLS_MOVE            = 7'd14,
        CLS_MOVE_FROM_SR    = 7'd15,
        CLS_NEGX            = 7'd16,
        CLS_CLR             = 7'd17,
        CLS_MOVE_TO_CCR     = 7'd18,
        CLS_NEG             = 7'd19,
        CLS_MOVE_TO_SR      = 7'd20,
        CLS_NOT             = 7'd21,
        CLS_NBCD            = 7'd22,
        CLS_SWAP            = 7'd23,
        CLS_PEA             = 7'd24,
        CLS_EXT_W           = 7'd25,
        CLS_MOVEM_FROM_REGS = 7'd26,
        CLS_EXT_L           = 7'd27,
        CLS_ILLEGAL         = 7'd28,
        CLS_TAS             = 7'd29,
        CLS_TST             = 7'd30,
        CLS_MOVEM_TO_REGS   = 7'd31,
        CLS_TRAP            = 7'd32,
        CLS_LINK            = 7'd33,
        CLS_UNLK            = 7'd34,
        CLS_MOVE_TO_USP     = 7'd35,
        CLS_MOVE_FROM_USP   = 7'd36,
        CLS_RESET           = 7'd37,
        CLS_NOP             = 7'd38,
        CLS_STOP            = 7'd39,
        CLS_RTE             = 7'd40,
        CLS_RTS             = 7'd41,
        CLS_TRAPV           = 7'd42,
        CLS_RTR             = 7'd43,
        CLS_JSR             = 7'd44,
        CLS_JMP             = 7'd45,
        CLS_CHK             = 7'd46,
        CLS_LEA             = 7'd47,
        CLS_DBCC            = 7'd48,
        CLS_SCC             = 7'd49,
        CLS_ADDQ            = 7'd50,
        CLS_SUBQ            = 7'd51,
        CLS_BCC             = 7'd52,
        CLS_MOVEQ           = 7'd53,
        CLS_SBCD            = 7'd54,
        CLS_DIVS            = 7'd55,
        CLS_DIVU            = 7'd56,
        CLS_OR              = 7'd57,
        CLS_SUBX            = 7'd58,
        CLS_SUBA            = 7'd59,
        CLS_SUB             = 7'd60,
        CLS_LINE_A          = 7'd61,
        CLS_CMPM            = 7'd62,
        CLS_EOR             = 7'd63,
        CLS_CMPA            = 7'd64,
        CLS_CMP             = 7'd65,
        CLS_MULU            = 7'd66,
        CLS_MULS            = 7'd67,
        CLS_ABCD            = 7'd68,
        CLS_AND             = 7'd69,
        CLS_EXG_DATA        = 7'd70,
        CLS_EXG_ADDR        = 7'd71,
        CLS_EXG_MIXED       = 7'd72,
        CLS_ADDX            = 7'd73,
        CLS_ADDA            = 7'd74,
        CLS_ADD             = 7'd75,
        CLS_MEMORY_SHIFT    = 7'd76,
        CLS_REGISTER_SHIFT  = 7'd77,
        CLS_LINE_F          = 7'd78
    } t_instr_class;

endpackage

// File: rtl/core/m68k_opcode_class_decoder.sv
// Top level of the 68000 opcode class decoder: input register, decode, result register.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one 16-bit opcode word per request.
//   Master stream (o_m_axis_*) returns one instruction class per request, in
//   order: 0 for no class, 1..78 for the classes, 61 for any line-A word and
//   78 for any line-F word.
//   A request is taken on a rising edge with tvalid and tready both high.
// Pipeline:
//   Two stages: the word is held in an input register, decoded by short
//   field logic, and the class lands in the result register. A taken request
//   passes both registers before its result is offered. One request is taken
//   per cycle unless the result stalls, set by the single reg-to-reg decode path.
// Reset:
//   i_rst_n is synchronous and active low; it drops both stage valids, so no
//   result is pending afterwards. No other state is kept.
// Stalls:
//   When the receiver holds i_m_axis_tready low, the result register holds
//   its class; the input register still takes one more request, and then
//   o_s_axis_tready drops until the result is taken. No request is lost.
module m68k_opcode_class_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] opcode_word
    // Results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [6:0] instr_class, [7] zero
);

    logic                                r_in_valid;
    logic                                n_in_valid;
    logic [m68kocd_pkg::OPCODE_W-1:0]    r_in_word;
    logic                                r_out_valid;
    logic                                n_out_valid;
    m68kocd_pkg::t_instr_class           r_out_class;
    m68kocd_pkg::t_instr_class           w_class;
    logic                                w_out_free;
    logic                                w_adv;
    logic                                w_accept;

    // Result register is free when empty or being drained this cycle.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    // Advance the held word into the result register.
    assign w_adv           = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    m68kocd_classify u_classify (
        .i_word  (r_in_word),
        .o_class (w_class)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept)
            n_in_valid = 1'b1;
        else if (w_adv)
            n_in_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (w_adv)
            n_out_valid = 1'b1;
        else if (i_m_axis_tready)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on the input handshake or on advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept)
            r_in_word <= i_s_axis_tdata;
        if (w_adv)
            r_out_class <= w_class;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(m68kocd_pkg::OUT_TDATA_W - m68kocd_pkg::CLASS_W){1'b0}},
                              r_out_class};

    // A taken request is always held in the input register next cycle.
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted request not held in input register");

    // A word that moves on lands in the result register with its decoded class.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (o_m_axis_tvalid && r_out_class == $past(w_class)))
        else $error("advanced word did not produce its class");

    // An empty input register never backs up the sender.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_axis_tready)
        else $error("input stalled while input register empty");

    // A stalled result keeps the input register from overwriting its word.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |=> $stable(r_in_word))
        else $error("input word lost during a result stall");

endmodule

// File: rtl/core/m68kocd_classify.sv
// Combinational field decode of one 68000 opcode word into its class.
module m68kocd_classify (
    input  logic [m68kocd_pkg::OPCODE_W-1:0] i_word,
    output m68kocd_pkg::t_instr_class        o_class
);

    logic [3:0] w_line;
    logic [2:0] w_om;
    logic       w_b8;
    logic [1:0] w_sz;
    logic [2:0] w_mode;
    logic [4:0] w_sel;

    assign w_line = i_word[15:12];
    assign w_om   = i_word[8:6];
    assign w_b8   = i_word[8];
    assign w_sz   = i_word[7:6];
    assign w_mode = i_word[5:3];
    assign w_sel  = i_word[7:3];

    // Line 0: immediates, bit operations and MOVEP.
    function automatic m68kocd_pkg::t_instr_class dec_line0(input logic [15:0] w);
        m68kocd_pkg::t_instr_class c;
        logic ccr;
        ccr = (w[7:0] == m68kocd_pkg::LOW8_CCR);
        unique case (w[11:8])
            4'd12:   c = m68kocd_pkg::CLS_CMPI;
            4'd10:   c = ccr ? m68kocd_pkg::CLS_EORI_CCR : m68kocd_pkg::CLS_EORI;
            4'd6:    c = m68kocd_pkg::CLS_ADDI;
            4'd4:    c = m68kocd_pkg::CLS_SUBI;
            4'd2:    c = ccr ? m68kocd_pkg::CLS_ANDI_CCR : m68kocd_pkg::CLS_ANDI;
            4'd0:    c = ccr ? m68kocd_pkg::CLS_ORI_CCR : m68kocd_pkg::CLS_ORI;
            4'd8:    c = m68kocd_pkg::CLS_STATIC_BIT;
            default: begin
                if (w[8] && w[5:3] == 3'd1)
                    c = m68kocd_pkg::CLS_MOVEP;
                else if (w[8])
                    c = m68kocd_pkg::CLS_DYNAMIC_BIT;
                else
                    c = m68kocd_pkg::CLS_NONE;
            end
        endcase
        return c;
    endfunction

    // Line 4, sub-line 14: trap, link, stack and control words, jumps.
    function automatic m68kocd_pkg::t_instr_class dec_misc(input logic [15:0] w);
        m68kocd_pkg::t_instr_class c;
        m68kocd_pkg::t_instr_class jump;
        if (w[7:6] == 2'd2)
            jump = m68kocd_pkg::CLS_JSR;
        else if (w[7:6] == 2'd3)
            jump = m68kocd_pkg::CLS_JMP;
        else
            jump = m68kocd_pkg::CLS_NONE;
        unique case (w[7:3])
            5'd8, 5'd9: c = m68kocd_pkg::CLS_TRAP;
            5'd10:      c = m68kocd_pkg::CLS_LINK;
            5'd11:      c = m68kocd_pkg::CLS_UNLK;
            5'd12:      c = m68kocd_pkg::CLS_MOVE_TO_USP;
            5'd13:      c = m68kocd_pkg::CLS_MOVE_FROM_USP;
            5'd14: begin
                unique case (w[2:0])
                    3'd0:    c = m68kocd_pkg::CLS_RESET;
                    3'd1:    c = m68kocd_pkg::CLS_NOP;
                    3'd2:    c = m68kocd_pkg::CLS_STOP;
                    3'd3:    c = m68kocd_pkg::CLS_RTE;
                    3'd5:    c = m68kocd_pkg::CLS_RTS;
                    3'd6:    c = m68kocd_pkg::CLS_TRAPV;
                    3'd7:    c = m68kocd_pkg::CLS_RTR;
                    default: c = jump;   // the gap in the control group falls through
                endcase
            end
            default:    c = jump;
        endcase
        return c;
    endfunction

    // Line 4: miscellaneous single-operand group.
    function automatic m68kocd_pkg::t_instr_class dec_line4(input logic [15:0] w);
        m68kocd_pkg::t_instr_class c;
        logic sz3;
        logic dreg;
        sz3  = (w[7:6] == 2'd3);
        dreg = (w[5:3] == 3'd0);
        unique case (w[11:8])
            4'd0:  c = sz3 ? m68kocd_pkg::CLS_MOVE_FROM_SR : m68kocd_pkg::CLS_NEGX;
            4'd2:  c = m68kocd_pkg::CLS_CLR;
            4'd4:  c = sz3 ? m68kocd_pkg::CLS_MOVE_TO_CCR : m68kocd_pkg::CLS_NEG;
            4'd6:  c = sz3 ? m68kocd_pkg::CLS_MOVE_TO_SR : m68kocd_pkg::CLS_NOT;
            4'd8: begin
                unique case (w[7:6])
                    2'd0:    c = m68kocd_pkg::CLS_NBCD;
                    2'd1:    c = dreg ? m68kocd_pkg::CLS_SWAP : m68kocd_pkg::CLS_PEA;
                    2'd2:    c = dreg ? m68kocd_pkg::CLS_EXT_W
                                      : m68kocd_pkg::CLS_MOVEM_FROM_REGS;
                    default: c = dreg ? m68kocd_pkg::CLS_EXT_L
                                      : m68kocd_pkg::CLS_MOVEM_FROM_REGS;
                endcase
            end
            4'd10: begin
                if (sz3)
                    c = (w[5:0] == m68kocd_pkg::EA_ILLEGAL) ? m68kocd_pkg::CLS_ILLEGAL
                                                            : m68kocd_pkg::CLS_TAS;
                else
                    c = m68kocd_pkg::CLS_TST;
            end
            4'd12: c = w[7] ? m68kocd_pkg::CLS_MOVEM_TO_REGS : m68kocd_pkg::CLS_NONE;
            4'd14: c = dec_misc(w);
            default: begin
                if (w[8:6] == 3'd6)
                    c = m68kocd_pkg::CLS_CHK;
                else if (w[8:6] == 3'd7)
                    c = m68kocd_pkg::CLS_LEA;
                else
                    c = m68kocd_pkg::CLS_NONE;
            end
        endcase
        return c;
    endfunction

    always_comb begin
        unique case (w_line)
            4'd0:             o_class = dec_line0(i_word);
            4'd1, 4'd2, 4'd3: o_class = (w_om == 3'd1) ? m68kocd_pkg::CLS_MOVEA
                                                       : m68kocd_pkg::CLS_MOVE;
            4'd4:             o_class = dec_line4(i_word);
            4'd5: begin
                if (w_sel == m68kocd_pkg::SEL_DBCC)
                    o_class = m68kocd_pkg::CLS_DBCC;
                else if (w_sz == 2'd3)
                    o_class = m68kocd_pkg::CLS_SCC;
                else
                    o_class = w_b8 ? m68kocd_pkg::CLS_SUBQ : m68kocd_pkg::CLS_ADDQ;
            end
            4'd6:  o_class = m68kocd_pkg::CLS_BCC;
            4'd7:  o_class = w_b8 ? m68kocd_pkg::CLS_NONE : m68kocd_pkg::CLS_MOVEQ;
            4'd8: begin
                if (i_word[8:4] == m68kocd_pkg::SEL_SBCD)
                    o_class = m68kocd_pkg::CLS_SBCD;
                else if (w_om == 3'd7)
                    o_class = m68kocd_pkg::CLS_DIVS;
                else if (w_om == 3'd3)
                    o_class = m68kocd_pkg::CLS_DIVU;
                else
                    o_class = m68kocd_pkg::CLS_OR;
            end
            4'd9: begin
                if (i_word[5:4] == 2'd0 && w_b8 && w_sz != 2'd3)
                    o_class = m68kocd_pkg::CLS_SUBX;
                else if (w_om == 3'd3 || w_om == 3'd7)
                    o_class = m68kocd_pkg::CLS_SUBA;
                else
                    o_class = m68kocd_pkg::CLS_SUB;
            end
            4'd10: o_class = m68kocd_pkg::CLS_LINE_A;
            4'd11: begin
                if (w_b8 && w_mode == 3'd1 && w_sz != 2'd3)
                    o_class = m68kocd_pkg::CLS_CMPM;
                else if (w_om == 3'd4 || w_om == 3'd5 || w_om == 3'd6)
                    o_class = m68kocd_pkg::CLS_EOR;
                else if (w_om == 3'd3 || w_om == 3'd7)
                    o_class = m68kocd_pkg::CLS_CMPA;
                else
                    o_class = m68kocd_pkg::CLS_CMP;
            end
            4'd12: begin
                if (w_om == 3'd3)
                    o_class = m68kocd_pkg::CLS_MULU;
                else if (w_om == 3'd7)
                    o_class = m68kocd_pkg::CLS_MULS;
                else if (w_om == 3'd4)
                    o_class = (i_word[5:4] == 2'd0) ? m68kocd_pkg::CLS_ABCD
                                                    : m68kocd_pkg::CLS_AND;
                else if (w_om == 3'd5 && w_mode == 3'd0)
                    o_class = m68kocd_pkg::CLS_EXG_DATA;
                else if (w_om == 3'd5 && w_mode == 3'd1)
                    o_class = m68kocd_pkg::CLS_EXG_ADDR;
                else if (w_om == 3'd6 && w_mode == 3'd1)
                    o_class = m68kocd_pkg::CLS_EXG_MIXED;
                else
                    o_class = m68kocd_pkg::CLS_AND;   // mixed exchange with other modes too
            end
            4'd13: begin
                if (w_b8 && i_word[5:4] == 2'd0 && w_sz != 2'd3)
                    o_class = m68kocd_pkg::CLS_ADDX;
                else if (w_om == 3'd3 || w_om == 3'd7)
                    o_class = m68kocd_pkg::CLS_ADDA;
                else
                    o_class = m68kocd_pkg::CLS_ADD;
            end
            4'd14: o_class = (w_sz == 2'd3 && !i_word[11]) ? m68kocd_pkg::CLS_MEMORY_SHIFT
                                                           : m68kocd_pkg::CLS_REGISTER_SHIFT;
            default: o_class = m68kocd_pkg::CLS_LINE_F;
        endcase
    end

endmodule

// File: test/m68k_opcode_class_decoder_tb.sv
// Self-checking stream testbench for the 68000 opcode class decoder, with its own class predictor.
`timescale 1ns / 100ps

module m68k_opcode_class_decoder_tb;
    import m68kocd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_CLASSES  = 79;
    localparam int MAX_REPORTED = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;    // [15:0] opcode_word
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;    // [6:0] instr_class, [7] zero

    // Classes predicted for accepted requests, oldest first.
    t_instr_class       pending_classes [$];
    t_instr_class       want_class;
    bit [NUM_CLASSES-1:0] classes_seen;

    int fail_count;
    int requests_sent;
    int results_seen;
    int input_stall_run;
    int longest_input_stall;
    int cycle_count;

    // Idling knobs for the sender task and the receiver process.
    int tx_max_gap;
    int rx_max_stall;
    int hold_off_req;
    int rx_wait_left;
    int rx_draw;
    bit rx_took;

    m68k_opcode_class_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Decode one opcode word the way the block is expected to: top nibble picks
    // the line, then sub-fields are tested in a fixed order per line.
    function automatic t_instr_class classify_opcode(input logic [15:0] w);
        logic [2:0] opm;
        logic [1:0] sz;
        logic [2:0] ea_mode;
        logic       b8;
        opm     = w[8:6];
        sz      = w[7:6];
        ea_mode = w[5:3];
        b8      = w[8];
        case (w[15:12])
            4'h0: begin
                case (w[11:8])
                    4'd12: return CLS_CMPI;
                    4'd10: return (w[7:0] == LOW8_CCR) ? CLS_EORI_CCR : CLS_EORI;
                    4'd6:  return CLS_ADDI;
                    4'd4:  return CLS_SUBI;
                    4'd2:  return (w[7:0] == LOW8_CCR) ? CLS_ANDI_CCR : CLS_ANDI;
                    4'd0:  return (w[7:0] == LOW8_CCR) ? CLS_ORI_CCR : CLS_ORI;
                    4'd8:  return CLS_STATIC_BIT;
                    default: begin
                        if (b8 && ea_mode == 3'd1) return CLS_MOVEP;
                        if (b8) return CLS_DYNAMIC_BIT;
                        return CLS_NONE;
                    end
                endcase
            end
            4'h1, 4'h2, 4'h3: return (opm == 3'd1) ? CLS_MOVEA : CLS_MOVE;
            4'h4: begin
                case (w[11:8])
                    4'd0: return (sz == 2'd3) ? CLS_MOVE_FROM_SR : CLS_NEGX;
                    4'd2: return CLS_CLR;
                    4'd4: return (sz == 2'd3) ? CLS_MOVE_TO_CCR : CLS_NEG;
                    4'd6: return (sz == 2'd3) ? CLS_MOVE_TO_SR : CLS_NOT;
                    4'd8: begin
                        if (sz == 2'd0) return CLS_NBCD;
                        if (sz == 2'd1) return (ea_mode == 3'd0) ? CLS_SWAP : CLS_PEA;
                        if (sz == 2'd2) return (ea_mode == 3'd0) ? CLS_EXT_W : CLS_MOVEM_FROM_REGS;
                        return (ea_mode == 3'd0) ? CLS_EXT_L : CLS_MOVEM_FROM_REGS;
                    end
                    4'd10: begin
                        if (sz == 2'd3) return (w[5:0] == EA_ILLEGAL) ? CLS_ILLEGAL : CLS_TAS;
                        return CLS_TST;
                    end
                    4'd12: return w[7] ? CLS_MOVEM_TO_REGS : CLS_NONE;
                    4'd14: begin
                        case (w[7:3])
                            5'd8, 5'd9: return CLS_TRAP;
                            5'd10:      return CLS_LINK;
                            5'd11:      return CLS_UNLK;
                            5'd12:      return CLS_MOVE_TO_USP;
                            5'd13:      return CLS_MOVE_FROM_USP;
                            5'd14: begin
                                // Code 4 has no entry and falls through below.
                                case (w[2:0])
                                    3'd0: return CLS_RESET;
                                    3'd1: return CLS_NOP;
                                    3'd2: return CLS_STOP;
                                    3'd3: return CLS_RTE;
                                    3'd5: return CLS_RTS;
                                    3'd6: return CLS_TRAPV;
                                    3'd7: return CLS_RTR;
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                        if (sz == 2'd2) return CLS_JSR;
                        if (sz == 2'd3) return CLS_JMP;
                        return CLS_NONE;
                    end
                    default: begin
                        if (opm == 3'd6) return CLS_CHK;
                        if (opm == 3'd7) return CLS_LEA;
                        return CLS_NONE;
                    end
                endcase
            end
            4'h5: begin
                if (w[7:3] == SEL_DBCC) return CLS_DBCC;
                if (sz == 2'd3) return CLS_SCC;
                return b8 ? CLS_SUBQ : CLS_ADDQ;
            end
            4'h6: return CLS_BCC;
            4'h7: return b8 ? CLS_NONE : CLS_MOVEQ;
            4'h8: begin
                if (w[8:4] == SEL_SBCD) return CLS_SBCD;
                if (opm == 3'd7) return CLS_DIVS;
                if (opm == 3'd3) return CLS_DIVU;
                return CLS_OR;
            end
            4'h9: begin
                if (w[5:4] == 2'd0 && b8 && sz <= 2'd2) return CLS_SUBX;
                if (opm == 3'd3 || opm == 3'd7) return CLS_SUBA;
                return CLS_SUB;
            end
            4'hA: return CLS_LINE_A;
            4'hB: begin
                if (b8 && ea_mode == 3'd1 && sz <= 2'd2) return CLS_CMPM;
                if (opm >= 3'd4 && opm <= 3'd6) return CLS_EOR;
                if (opm == 3'd3 || opm == 3'd7) return CLS_CMPA;
                return CLS_CMP;
            end
            4'hC: begin
                if (opm == 3'd3) return CLS_MULU;
                if (opm == 3'd7) return CLS_MULS;
                if (opm == 3'd4) return (w[5:4] == 2'd0) ? CLS_ABCD : CLS_AND;
                if (opm == 3'd5) begin
                    if (ea_mode == 3'd0) return CLS_EXG_DATA;
                    if (ea_mode == 3'd1) return CLS_EXG_ADDR;
                    return CLS_AND;
                end
                // Opmode 6 only exchanges with mode 1; everything else lands on AND.
                if (opm == 3'd6 && ea_mode == 3'd1) return CLS_EXG_MIXED;
                return CLS_AND;
            end
            4'hD: begin
                if (b8 && w[5:4] == 2'd0 && sz <= 2'd2) return CLS_ADDX;
                if (opm == 3'd3 || opm == 3'd7) return CLS_ADDA;
                return CLS_ADD;
            end
            4'hE: return (sz == 2'd3 && !w[11]) ? CLS_MEMORY_SHIFT : CLS_REGISTER_SHIFT;
            default: return CLS_LINE_F;
        endcase
    endfunction

    // Draw a random word, biased toward the lines with the densest sub-decode.
    function automatic logic [15:0] pick_opcode();
        logic [15:0] w;
        logic [3:0]  arith_lines [0:4];
        arith_lines = '{4'h5, 4'h8, 4'h9, 4'hB, 4'hD};
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            4, 5: begin
                w[15:8] = 8'h4E;
                if ($urandom_range(0, 2) != 0) w[7:3] = 5'($urandom_range(8, 14));
            end
            6: begin
                w[15:12] = 4'hC;
                w[8:6]   = 3'($urandom_range(4, 6));
                w[5:3]   = 3'($urandom_range(0, 2));
            end
            7: w[15:12] = 4'h0;
            8: w[15:12] = 4'h4;
            9: begin
                w[15:12] = arith_lines[$urandom_range(0, 4)];
                if ($urandom_range(0, 1) == 1) w[5:4] = 2'd0;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic log_failure(input string msg);
        if (fail_count < MAX_REPORTED) $display("%s", msg);
        fail_count++;
    endtask

    // Offer one request; called at a falling edge, returns at the falling edge
    // after the request was taken. Junk data rides along while valid is low.
    task automatic offer_opcode(input logic [15:0] w);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every outstanding class has come back.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_classes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Boundary words and the odd corners of the decode: CCR immediates, the
    // hole in the line-4 misc group, unlisted misc selectors, line 7 with
    // bit 8 set, the empty line-0 sub-line, the AND fall-through in line C.
    task automatic test_special_words();
        logic [15:0] words [0:24];
        words = '{16'h0000, 16'hFFFF, 16'h003C, 16'h023C, 16'h0A3C,
                  16'h0E00, 16'h0F08, 16'h0B00, 16'h7100, 16'h4E74,
                  16'h4E71, 16'h4E77, 16'h4E80, 16'h4EC0, 16'h4E30,
                  16'h4AFC, 16'h4AC0, 16'hC180, 16'hC188, 16'hC148,
                  16'hC140, 16'hA000, 16'hE0C0, 16'hE8C0, 16'h51C8};
        tx_max_gap   = 14;
        rx_max_stall = 14;
        foreach (words[k]) offer_opcode(words[k]);
    endtask

    // Hit every class at least once: scan the word space from a random start
    // for the first word of each class.
    task automatic test_class_sweep();
        logic [15:0] w;
        int          tries;
        for (int cls = 0; cls < NUM_CLASSES; cls++) begin
            w     = 16'($urandom);
            tries = 0;
            while (classify_opcode(w) != t_instr_class'(cls) && tries < 65536) begin
                w++;
                tries++;
            end
            offer_opcode(w);
        end
    endtask

    // Random words in four phases: both sides idling, neither, and each alone.
    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++) begin
            tx_max_gap   = (phase == 0 || phase == 2) ? 14 : 0;
            rx_max_stall = (phase == 0 || phase == 3) ? 14 : 0;
            repeat (275) offer_opcode(pick_opcode());
        end
        tx_max_gap   = 14;
        rx_max_stall = 14;
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the pipeline fills and the input side stalls.
    task automatic test_output_backpressure();
        tx_max_gap   = 0;
        hold_off_req = 200;
        repeat (40) offer_opcode(pick_opcode());
        tx_max_gap   = 14;
    endtask

    // Pause the sender until the block is empty, then resume.
    task automatic test_drain_pause();
        repeat (30) offer_opcode(pick_opcode());
        wait_results_drained();
        repeat (30) offer_opcode(pick_opcode());
    endtask

    // Receiver: after each taken result, draw a stall; a requested hold-off
    // takes precedence and is counted down here, one cycle per falling edge.
    initial begin
        i_m_axis_tready = 1'b0;
        rx_wait_left    = 0;
        forever begin
            @(negedge i_clk);
            if (rx_wait_left > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_wait_left--;
            end else if (hold_off_req > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_wait_left = hold_off_req - 1;
                hold_off_req = 0;
            end else if (rx_took) begin
                rx_draw = $urandom_range(0, rx_max_stall);
                if (rx_draw > 0) begin
                    i_m_axis_tready <= 1'b0;
                    rx_wait_left = rx_draw - 1;
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction, then
    // record the prediction for each taken request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_classes.size() == 0) begin
                    log_failure($sformatf("unexpected result: tdata=%h", o_m_axis_tdata));
                end else begin
                    want_class = pending_classes.pop_front();
                    results_seen++;
                    if (o_m_axis_tdata[6:0] < NUM_CLASSES)
                        classes_seen[o_m_axis_tdata[6:0]] = 1'b1;
                    if (o_m_axis_tdata !== {1'b0, want_class})
                        log_failure($sformatf(
                            "class mismatch on result %0d: expected %0d (%s), got class %0d pad %b",
                            results_seen, want_class, want_class.name(),
                            o_m_axis_tdata[6:0], o_m_axis_tdata[7]));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                pending_classes.push_back(classify_opcode(i_s_axis_tdata));
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                input_stall_run++;
                if (input_stall_run > longest_input_stall) longest_input_stall = input_stall_run;
            end else begin
                input_stall_run = 0;
            end
        end
        rx_took = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
    end

    // Watchdog: end the run if it has not finished by the cycle limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_classes.size());
        $display("m68k_opcode_class_decoder_tb: errors");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 16'h0000;
        tx_max_gap      = 14;
        rx_max_stall    = 14;
        hold_off_req    = 0;
        rx_took         = 1'b0;
        classes_seen    = '0;
        fail_count      = 0;
        requests_sent   = 0;
        results_seen    = 0;
        input_stall_run = 0;
        longest_input_stall = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_words();
        test_class_sweep();
        test_random_mix();
        test_output_backpressure();
        test_drain_pause();

        // Flush, then give the two-stage pipe time to show any stray result.
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (pending_classes.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_classes.size()));

        $display("sent %0d opcode words, checked %0d classes, %0d of %0d class codes seen",
                 requests_sent, results_seen, $countones(classes_seen), NUM_CLASSES);
        $display("longest input stall %0d cycles, %0d failures", longest_input_stall, fail_count);
        if (fail_count == 0) begin
            $display("m68k_opcode_class_decoder_tb: clean");
        end else begin
            $display("m68k_opcode_class_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/m68kocd_pkg.sv
rtl/core/m68kocd_classify.sv
rtl/core/m68k_opcode_class_decoder.sv
test/m68k_opcode_class_decoder_tb.sv
